@@ rtl/dq_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package dq_pkg;

    typedef enum logic [2:0] {
        OP_PUSH_FRONT = 3'd0,
        OP_PUSH_BACK  = 3'd1,
        OP_POP_FRONT  = 3'd2,
        OP_POP_BACK   = 3'd3,
        OP_PEEK_FRONT = 3'd4,
        OP_PEEK_BACK  = 3'd5,
        OP_CLEAR      = 3'd6
    } t_op;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_VALUE = 2'd1,
        ST_EMPTY = 2'd2,
        ST_FULL  = 2'd3
    } t_status;

    localparam int unsigned WORD_W = 32;

    typedef struct packed {
        t_op                 operation;
        logic [WORD_W-1:0]   data_word;
    } t_req;

    typedef struct packed {
        t_status             status;
        logic [WORD_W-1:0]   result_word;
    } t_rsp;

    // result of one request, waiting for the ram read data
    typedef struct packed {
        logic                valid;
        t_status             status;
        logic                use_rdata;
    } t_pend;

endpackage

`default_nettype wire

@@ rtl/dq_ram.sv @@
`timescale 1ns / 1ps
`default_nettype none

module dq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

@@ rtl/dq_ctrl.sv @@
`timescale 1ns / 1ps
`default_nettype none

module dq_ctrl #(
    parameter int DEPTH      = 16,
    parameter int DATA_WIDTH = 32
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_accept,
    input  wire dq_pkg::t_req             i_req,
    output logic                          o_we,
    output logic [$clog2(DEPTH)-1:0]      o_waddr,
    output logic [DATA_WIDTH-1:0]         o_wdata,
    output logic                          o_re,
    output logic [$clog2(DEPTH)-1:0]      o_raddr,
    output dq_pkg::t_pend                 o_pend
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int SW = AW + 2;

    logic [AW-1:0]     r_head;
    logic [AW-1:0]     n_head;
    logic [CW-1:0]     r_count;
    logic [CW-1:0]     n_count;
    dq_pkg::t_pend     r_pend;
    dq_pkg::t_pend     n_pend;

    logic [SW-1:0]     tail_sum;
    logic [SW-1:0]     back_sum;
    logic [AW-1:0]     tail_slot;
    logic [AW-1:0]     back_slot;
    logic [AW-1:0]     head_inc;
    logic [AW-1:0]     head_dec;
    logic              full;
    logic              empty;

    // slot after the last entry, and the last entry itself, wrapped into the ring
    always_comb begin
        tail_sum  = SW'(r_head) + SW'(r_count);
        back_sum  = tail_sum - SW'(1);
        tail_slot = (tail_sum >= SW'(DEPTH)) ? AW'(tail_sum - SW'(DEPTH)) : AW'(tail_sum);
        back_slot = (back_sum >= SW'(DEPTH)) ? AW'(back_sum - SW'(DEPTH)) : AW'(back_sum);
        head_inc  = (r_head == AW'(DEPTH - 1)) ? '0 : r_head + AW'(1);
        head_dec  = (r_head == '0) ? AW'(DEPTH - 1) : r_head - AW'(1);
        full      = (r_count == CW'(DEPTH));
        empty     = (r_count == '0);
    end

    assign o_wdata = DATA_WIDTH'({32'h0, i_req.data_word});

    always_comb begin
        n_head           = r_head;
        n_count          = r_count;
        o_we             = 1'b0;
        o_waddr          = tail_slot;
        o_re             = 1'b0;
        o_raddr          = r_head;
        n_pend.valid     = i_accept;
        n_pend.status    = dq_pkg::ST_OK;
        n_pend.use_rdata = 1'b0;
        if (i_accept) begin
            unique case (i_req.operation)
                dq_pkg::OP_PUSH_FRONT, dq_pkg::OP_PUSH_BACK: begin
                    if (full) begin
                        n_pend.status = dq_pkg::ST_FULL;
                    end else begin
                        o_we    = 1'b1;
                        n_count = r_count + CW'(1);
                        if (i_req.operation == dq_pkg::OP_PUSH_FRONT) begin
                            o_waddr = head_dec;
                            n_head  = head_dec;
                        end
                    end
                end
                dq_pkg::OP_POP_FRONT, dq_pkg::OP_POP_BACK,
                dq_pkg::OP_PEEK_FRONT, dq_pkg::OP_PEEK_BACK: begin
                    if (empty) begin
                        n_pend.status = dq_pkg::ST_EMPTY;
                    end else begin
                        o_re             = 1'b1;
                        n_pend.status    = dq_pkg::ST_VALUE;
                        n_pend.use_rdata = 1'b1;
                        if (i_req.operation == dq_pkg::OP_POP_BACK ||
                            i_req.operation == dq_pkg::OP_PEEK_BACK) begin
                            o_raddr = back_slot;
                        end
                        if (i_req.operation == dq_pkg::OP_POP_FRONT) begin
                            n_head  = head_inc;
                            n_count = r_count - CW'(1);
                        end else if (i_req.operation == dq_pkg::OP_POP_BACK) begin
                            n_count = r_count - CW'(1);
                        end
                    end
                end
                dq_pkg::OP_CLEAR: begin
                    n_head  = '0;
                    n_count = '0;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_count <= '0;
            r_pend  <= '0;
        end else begin
            r_head  <= n_head;
            r_count <= n_count;
            r_pend  <= n_pend;
        end
    end

    assign o_pend = r_pend;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("entry count beyond depth");

    a_head_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_head <= AW'(DEPTH - 1))
        else $error("head index outside ring");

    a_one_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_accept |=> r_pend.valid)
        else $error("accepted request produced no result");

    a_idle_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_accept |=> ($stable(r_count) && $stable(r_head)))
        else $error("pointers moved without a request");

    a_one_port: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_we && o_re))
        else $error("read and write in the same request");

endmodule

`default_nettype wire

@@ rtl/double_ended_queue.sv @@
`timescale 1ns / 1ps
`default_nettype none

// double-ended queue of DATA_WIDTH-bit words in a ring of DEPTH entries
// request channel: start with i_req (operation, data_word); a request is taken
//   on a rising edge where start is high and busy is low
// result channel: o_valid is high for exactly one cycle per request, with o_rsp
//   (status, result_word); the receiver cannot hold results off
// latency: the result appears in the cycle after the request is taken
// throughput: one request per cycle unless busy; each request touches the ram
//   at most once (a write for a push, a read for a pop or peek), and head and count
//   are updated on the same edge, so back-to-back requests need no forwarding
// reset (synchronous, i_rst_n low): the queue is empty, head is zero, no
//   result is pending; busy is high through reset and for the first cycle
//   after reset is released
// stored words are not cleared by reset or by the clear operation; only live
//   entries are ever read
// a push to a full queue or a pop or peek of an empty one changes nothing and
//   reports an error status with a zero word
module double_ended_queue #(
    parameter int DEPTH      = 16,
    parameter int DATA_WIDTH = 32
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          start,
    output logic               busy,
    input  wire dq_pkg::t_req  i_req,
    output logic               o_valid,
    output dq_pkg::t_rsp       o_rsp
);

    localparam int AW = $clog2(DEPTH);

    logic                  accept;
    logic                  we;
    logic [AW-1:0]         waddr;
    logic [DATA_WIDTH-1:0] wdata;
    logic                  re;
    logic [AW-1:0]         raddr;
    logic [DATA_WIDTH-1:0] rdata;
    dq_pkg::t_pend         pend;
    logic                  r_busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b1;
        end else begin
            r_busy <= 1'b0;
        end
    end

    assign busy   = r_busy;
    assign accept = start && !r_busy;

    dq_ctrl #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_req    (i_req),
        .o_we     (we),
        .o_waddr  (waddr),
        .o_wdata  (wdata),
        .o_re     (re),
        .o_raddr  (raddr),
        .o_pend   (pend)
    );

    dq_ram #(
        .WIDTH (DATA_WIDTH),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_re    (re),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    assign o_valid           = pend.valid;
    assign o_rsp.status      = pend.status;
    assign o_rsp.result_word = pend.use_rdata ? 32'({64'h0, rdata}) : 32'h0;

endmodule

`default_nettype wire

@@ verif/tb_double_ended_queue.sv @@
`timescale 1ns / 1ps

module tb_double_ended_queue;
    import dq_pkg::*;

    localparam int DEPTH      = 16;
    localparam int DATA_WIDTH = 32;
    localparam int N_RANDOM   = 1850;
    localparam int N_STEADY   = 200;
    localparam logic [2:0] OP_CODE_UNUSED = 3'd7;

    typedef struct packed {
        t_op          op;
        logic [31:0]  word;
        logic [4:0]   reps;
        logic         fixed;
        t_status      st;
        logic [31:0]  rword;
    } t_plan_row;

    localparam int N_ROWS = 25;
    localparam t_plan_row PLAN [N_ROWS] = '{
        '{OP_POP_FRONT,       32'h0,        5'd1,  1'b1, ST_EMPTY, 32'h0},
        '{OP_POP_BACK,        32'h0,        5'd1,  1'b1, ST_EMPTY, 32'h0},
        '{OP_PEEK_FRONT,      32'h0,        5'd1,  1'b1, ST_EMPTY, 32'h0},
        '{OP_PEEK_BACK,       32'h0,        5'd1,  1'b1, ST_EMPTY, 32'h0},
        '{OP_PUSH_BACK,       32'h0,        5'd1,  1'b1, ST_OK,    32'h0},
        '{OP_PUSH_FRONT,      32'hFFFFFFFF, 5'd1,  1'b1, ST_OK,    32'h0},
        '{OP_PEEK_FRONT,      32'h0,        5'd1,  1'b1, ST_VALUE, 32'hFFFFFFFF},
        '{OP_PEEK_BACK,       32'h0,        5'd1,  1'b1, ST_VALUE, 32'h0},
        '{t_op'(OP_CODE_UNUSED), 32'hFFFFFFFF, 5'd1, 1'b1, ST_OK,  32'h0},
        '{OP_POP_BACK,        32'h0,        5'd1,  1'b1, ST_VALUE, 32'h0},
        '{OP_POP_FRONT,       32'h0,        5'd1,  1'b1, ST_VALUE, 32'hFFFFFFFF},
        '{OP_POP_FRONT,       32'h0,        5'd1,  1'b1, ST_EMPTY, 32'h0},
        '{OP_PUSH_BACK,       32'hAAAA0000, 5'd16, 1'b1, ST_OK,    32'h0},
        '{OP_PUSH_FRONT,      32'h12345678, 5'd1,  1'b1, ST_FULL,  32'h0},
        '{OP_PUSH_BACK,       32'h55555555, 5'd1,  1'b1, ST_FULL,  32'h0},
        '{OP_PEEK_BACK,       32'h0,        5'd1,  1'b0, ST_OK,    32'h0},
        '{OP_POP_FRONT,       32'h0,        5'd4,  1'b0, ST_OK,    32'h0},
        '{OP_PUSH_BACK,       32'h5555AAAA, 5'd4,  1'b0, ST_OK,    32'h0},
        '{OP_PEEK_FRONT,      32'h0,        5'd1,  1'b0, ST_OK,    32'h0},
        '{OP_POP_BACK,        32'h0,        5'd1,  1'b0, ST_OK,    32'h0},
        '{OP_CLEAR,           32'h0,        5'd1,  1'b1, ST_OK,    32'h0},
        '{OP_PEEK_BACK,       32'h0,        5'd1,  1'b1, ST_EMPTY, 32'h0},
        '{OP_PUSH_FRONT,      32'hDEADBEEF, 5'd2,  1'b0, ST_OK,    32'h0},
        '{OP_POP_BACK,        32'h0,        5'd2,  1'b0, ST_OK,    32'h0},
        '{OP_CLEAR,           32'h0,        5'd1,  1'b1, ST_OK,    32'h0}
    };

    logic  i_clk;
    logic  i_rst_n;
    logic  start;
    logic  busy;
    t_req  i_req;
    logic  o_valid;
    t_rsp  o_rsp;

    // typed-in expectation travels with the request it belongs to
    logic  req_fixed;
    t_rsp  req_fixed_rsp;

    // shadow of the queue
    logic [DATA_WIDTH-1:0] ring_words [DEPTH];
    int head_slot  = 0;
    int live_count = 0;

    t_rsp pending_rsp [$];

    int n_errors = 0;
    int n_reqs   = 0;
    int n_values = 0;
    int n_full   = 0;
    int n_empty  = 0;
    int n_clears = 0;

    double_ended_queue #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_req   (i_req),
        .o_valid (o_valid),
        .o_rsp   (o_rsp)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    function automatic t_rsp deque_apply(input t_req r);
        t_rsp rsp;
        int   slot;
        rsp.status      = ST_OK;
        rsp.result_word = '0;
        case (r.operation)
            OP_PUSH_FRONT, OP_PUSH_BACK: begin
                if (live_count >= DEPTH) begin
                    rsp.status = ST_FULL;
                end else begin
                    if (r.operation == OP_PUSH_FRONT) begin
                        head_slot = (head_slot + DEPTH - 1) % DEPTH;
                        slot      = head_slot;
                    end else begin
                        slot = (head_slot + live_count) % DEPTH;
                    end
                    ring_words[slot] = r.data_word[DATA_WIDTH-1:0];
                    live_count++;
                end
            end
            OP_POP_FRONT, OP_POP_BACK, OP_PEEK_FRONT, OP_PEEK_BACK: begin
                if (live_count == 0) begin
                    rsp.status = ST_EMPTY;
                end else begin
                    if (r.operation == OP_POP_FRONT || r.operation == OP_PEEK_FRONT)
                        slot = head_slot;
                    else
                        slot = (head_slot + live_count - 1) % DEPTH;
                    rsp.result_word = ring_words[slot];
                    rsp.status      = ST_VALUE;
                    if (r.operation == OP_POP_FRONT) begin
                        head_slot = (head_slot + 1) % DEPTH;
                        live_count--;
                    end else if (r.operation == OP_POP_BACK) begin
                        live_count--;
                    end
                end
            end
            OP_CLEAR: begin
                head_slot  = 0;
                live_count = 0;
            end
            default: ;
        endcase
        return rsp;
    endfunction

    // outputs sampled before the edge updates them
    always @(posedge i_clk) begin
        t_rsp want;
        t_rsp pred;
        if (i_rst_n && o_valid) begin
            if (pending_rsp.size() == 0) begin
                $error("result with no request waiting: status %0d word %h",
                       o_rsp.status, o_rsp.result_word);
                n_errors++;
            end else begin
                want = pending_rsp.pop_front();
                if (o_rsp.status !== want.status) begin
                    $error("status: expected %0d, actual %0d", want.status, o_rsp.status);
                    n_errors++;
                end
                if (o_rsp.result_word !== want.result_word) begin
                    $error("result_word: expected %h, actual %h",
                           want.result_word, o_rsp.result_word);
                    n_errors++;
                end
            end
        end
        if (i_rst_n && start && !busy) begin
            pred = deque_apply(i_req);
            pending_rsp.push_back(req_fixed ? req_fixed_rsp : pred);
            n_reqs++;
            case (pred.status)
                ST_VALUE: n_values++;
                ST_FULL:  n_full++;
                ST_EMPTY: n_empty++;
                default:  ;
            endcase
            if (i_req.operation == OP_CLEAR)
                n_clears++;
        end
    end

    task automatic issue(input t_req r, input logic fixed, input t_rsp want);
        i_req         <= r;
        req_fixed     <= fixed;
        req_fixed_rsp <= want;
        start         <= 1'b1;
        do @(posedge i_clk); while (busy !== 1'b0);
    endtask

    task automatic idle(input int n);
        start <= 1'b0;
        repeat (n) @(posedge i_clk);
    endtask

    initial begin
        t_req r;
        t_rsp want;
        int   push_bias;
        int   pick;
        int   waited;
        start         <= 1'b0;
        i_req         <= '0;
        req_fixed     <= 1'b0;
        req_fixed_rsp <= '0;
        i_rst_n       <= 1'b0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int i = 0; i < N_ROWS; i++) begin
            for (int k = 0; k < PLAN[i].reps; k++) begin
                r.operation      = PLAN[i].op;
                r.data_word      = PLAN[i].word + k;
                want.status      = PLAN[i].st;
                want.result_word = PLAN[i].rword;
                issue(r, PLAN[i].fixed, want);
                if ($urandom_range(0, 5) == 0)
                    idle($urandom_range(1, 16));
            end
        end

        push_bias = 50;
        want      = '0;
        for (int k = 0; k < N_RANDOM; k++) begin
            // drift between filling and draining so both ends get hit
            if (k % 64 == 0)
                push_bias = $urandom_range(10, 90);
            pick = $urandom_range(0, 99);
            if (pick < 2)
                r.operation = OP_CLEAR;
            else if (pick < 3)
                r.operation = t_op'(OP_CODE_UNUSED);
            else if ($urandom_range(0, 99) < push_bias)
                r.operation = $urandom_range(0, 1) ? OP_PUSH_BACK : OP_PUSH_FRONT;
            else
                r.operation = t_op'($urandom_range(OP_POP_FRONT, OP_PEEK_BACK));
            case ($urandom_range(0, 7))
                0:       r.data_word = '0;
                1:       r.data_word = '1;
                default: r.data_word = $urandom;
            endcase
            issue(r, 1'b0, want);
            if (k == N_RANDOM / 2) begin
                start <= 1'b0;
                do @(posedge i_clk); while (pending_rsp.size() != 0);
            end else if (k < N_RANDOM - N_STEADY && $urandom_range(0, 7) == 0) begin
                idle($urandom_range(1, 16));
            end
        end
        start <= 1'b0;

        waited = 0;
        while (pending_rsp.size() != 0 && waited < 1000) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (8) @(posedge i_clk);
        if (pending_rsp.size() != 0) begin
            $error("%0d results never arrived", pending_rsp.size());
            n_errors++;
        end

        $display("ran %0d requests: %0d words returned, %0d full and %0d empty rejects,",
                 n_reqs, n_values, n_full, n_empty);
        $display("%0d clears, with random stalls and one full drain", n_clears);
        if (n_errors == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

    initial begin
        #2ms;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
